>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the windowed mean and deviation unit.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define WMSD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("windowed_mean_stddev_unit: assertion failed");
// Check that a condition never holds outside reset.
`define WMSD_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("windowed_mean_stddev_unit: forbidden condition seen");
`else
`define WMSD_ASSERT(lbl, clk, rstn, prop)
`define WMSD_NEVER(lbl, clk, rstn, cond)
`endif

`endif

>>> rtl/wmsd_pkg.sv
// Shared types and constants of the windowed mean and deviation unit.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package wmsd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 48;

    // Request kinds carried on s_tuser
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // latch sample, read ring entry under the pointer
        logic clear;     // zero pointer, count, sums and latest sample
        logic update;    // write ring, advance pointer and count, update sums
        logic mul;       // square the sum, scale the square sum, form the mean
        logic sub;       // form the variance numerator, start the root
        logic step;      // one root bit
        logic div;       // scale the root down by the window length
        logic load_out;  // load the result register
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic full;      // window holds a full set of samples
    } status_t;

endpackage

>>> rtl/windowed_mean_stddev_unit.sv
// Windowed mean and standard deviation unit.
// Input stream s_*: tuser[0] = operation (0 add sample, 1 clear), tdata = sample.
// Output stream m_*: tdata = latest, mean_value, std_dev (low to high); tuser = full.
// Each request gives exactly one result. The unit keeps the last WINDOW samples
// in a ring memory with running sum and sum of squares; mean and deviation read
// zero until WINDOW samples have been added since the last clear.
// Steps per request (from acceptance until the result can be loaded):
//   clear: capture and clear, then load; add with window not full: update, then multiply;
//   add with window full: update, multiply, subtract, then the bit-serial square
//   root, one root bit per cycle over 16 + clog2(WINDOW) bits, then divide.
//   One request is in work at a time.
// m_tvalid rises the cycle after the result is loaded. The result register holds
// while m_tready is low; the next request is accepted meanwhile and its result
// waits until the register is taken.
// Reset (aresetn low, synchronous) empties the window, zeroes the sums and
// drops m_tvalid; the ring needs no clearing pass since the fill count masks it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module windowed_mean_stddev_unit #(
    parameter int WINDOW = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [wmsd_pkg::S_TDATA_W-1:0]     s_tdata,   // [15:0] sample
    input  logic [0:0]                         s_tuser,   // [0] operation
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [wmsd_pkg::M_TDATA_W-1:0]     m_tdata,   // [15:0] latest,
                                                          // [31:16] mean_value,
                                                          // [47:32] std_dev
    output logic [0:0]                         m_tuser    // [0] window_full
);

    wmsd_pkg::cmd_t    cmd;
    wmsd_pkg::status_t status;

    logic signed [wmsd_pkg::SAMPLE_W-1:0] out_latest;
    logic                                 out_full;
    logic signed [wmsd_pkg::SAMPLE_W-1:0] out_mean;
    logic        [wmsd_pkg::SAMPLE_W-1:0] out_sd;
    logic                                 clear_req;

    wmsd_controller #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op_in    (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    wmsd_datapath #(
        .WINDOW (WINDOW)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sample_in  (signed'(s_tdata[wmsd_pkg::SAMPLE_W-1:0])),
        .status     (status),
        .out_latest (out_latest),
        .out_full   (out_full),
        .out_mean   (out_mean),
        .out_sd     (out_sd)
    );

    // Pack the result fields
    assign m_tdata = {out_sd, out_mean, out_latest};
    assign m_tuser = out_full;

    // Flag an accepted clear request
    assign clear_req = s_tvalid && s_tready && (s_tuser[0] == wmsd_pkg::OP_CLEAR);

    // A waiting result is never overwritten
    `WMSD_NEVER(a_no_overwrite, aclk, aresetn, cmd.load_out && m_tvalid && !m_tready)
    // Statistics are zero when the window is not full
    `WMSD_ASSERT(a_zero_stats, aclk, aresetn, (m_tvalid && !m_tuser[0]) |-> (m_tdata[47:16] == '0))
    // A clear request empties the window at once
    `WMSD_ASSERT(a_clear_empties, aclk, aresetn, clear_req |=> !status.full)

endmodule

>>> rtl/wmsd_datapath.sv
// Datapath: sample ring memory, running sums, variance numerator, bit-serial
// square root and reciprocal scaling. Depends on wmsd_pkg.
`timescale 1ns / 1ps

module wmsd_datapath #(
    parameter int WINDOW = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  wmsd_pkg::cmd_t                       cmd,
    input  logic signed [wmsd_pkg::SAMPLE_W-1:0] sample_in,
    output wmsd_pkg::status_t                    status,
    output logic signed [wmsd_pkg::SAMPLE_W-1:0] out_latest,
    output logic                                 out_full,
    output logic signed [wmsd_pkg::SAMPLE_W-1:0] out_mean,
    output logic        [wmsd_pkg::SAMPLE_W-1:0] out_sd
);

    localparam int SW    = wmsd_pkg::SAMPLE_W;
    localparam int LOG_W = $clog2(WINDOW);
    localparam int PTR_W = (LOG_W > 0) ? LOG_W : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = 17 + LOG_W;
    localparam int SQ_W  = 31 + LOG_W;
    localparam int NUM_W = 31 + 2 * LOG_W;
    localparam int RT_W  = 16 + LOG_W;
    localparam int X_W   = 2 * RT_W;
    localparam int D_W   = 16 + LOG_W;
    localparam int K_SH  = D_W + LOG_W;
    localparam int RC_W  = K_SH + 1;
    localparam int PR_W  = D_W + RC_W;

    // ceil(2^K_SH / WINDOW): exact floor division for dividends below 2^D_W
    localparam logic [RC_W-1:0] RECIP =
        RC_W'(((65'd1 << K_SH) + 65'(WINDOW) - 65'd1) / 65'(WINDOW));
    // Bias that makes the sum non-negative before the mean is taken
    localparam logic signed [SUM_W-1:0] MEAN_BIAS = SUM_W'(WINDOW * 32768);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

    // Ring memory: read and written in clocked blocks
    logic signed [SW-1:0] ring_mem [WINDOW];

    logic signed [SW-1:0]    sample_reg;
    logic signed [SW-1:0]    rdata_reg;
    logic [PTR_W-1:0]        ptr_reg, ptr_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SQ_W-1:0]         sq_reg, sq_next;
    logic signed [SW-1:0]    latest_reg;
    logic [NUM_W-1:0]        sos_reg, scaled_reg;
    logic [SW-1:0]           mean_reg;
    logic [X_W-1:0]          x_reg;
    logic [RT_W+1:0]         rem_reg;
    logic [RT_W-1:0]         root_reg;
    logic [SW-1:0]           sd_reg;
    logic signed [SW-1:0]    res_latest_reg;
    logic                    res_full_reg;
    logic [SW-1:0]           res_mean_reg;
    logic [SW-1:0]           res_sd_reg;

    logic                    full;
    logic signed [SW-1:0]    old_val;
    logic signed [2*SW-1:0]  new_prod, old_prod;
    logic signed [2*SUM_W-1:0] sum_sq;
    logic signed [SUM_W-1:0] biased_sum;
    logic [PR_W-1:0]         mean_prod, sd_prod;
    logic [RT_W+3:0]         rem_shift, trial, rem_diff;
    logic                    take;

    assign full        = (cnt_reg == CNT_FULL);
    assign status.full = full;

    // Entries past the fill count were not written since clear and read as zero
    assign old_val  = full ? rdata_reg : '0;
    assign new_prod = sample_reg * sample_reg;
    assign old_prod = old_val * old_val;

    assign sum_next = sum_reg + SUM_W'(sample_reg) - SUM_W'(old_val);
    assign sq_next  = sq_reg + SQ_W'(new_prod[2*SW-2:0]) - SQ_W'(old_prod[2*SW-2:0]);
    assign ptr_next = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + PTR_W'(1);
    assign cnt_next = full ? cnt_reg : cnt_reg + CNT_W'(1);

    // Ring read at request time, write during update
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sample_reg <= sample_in;
            rdata_reg  <= ring_mem[ptr_reg];
        end
        if (cmd.update) begin
            ring_mem[ptr_reg] <= sample_reg;
        end
    end

    // Window state: pointer, fill count, sums, latest sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg    <= '0;
            cnt_reg    <= '0;
            sum_reg    <= '0;
            sq_reg     <= '0;
            latest_reg <= '0;
        end else if (cmd.clear) begin
            ptr_reg    <= '0;
            cnt_reg    <= '0;
            sum_reg    <= '0;
            sq_reg     <= '0;
            latest_reg <= '0;
        end else if (cmd.update) begin
            ptr_reg    <= ptr_next;
            cnt_reg    <= cnt_next;
            sum_reg    <= sum_next;
            sq_reg     <= sq_next;
            latest_reg <= sample_reg;
        end
    end

    // Square of the sum, scaled square sum, and floor mean by reciprocal
    assign sum_sq     = sum_reg * sum_reg;
    assign biased_sum = sum_reg + MEAN_BIAS;
    assign mean_prod  = PR_W'(biased_sum[D_W-1:0]) * PR_W'(RECIP);

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            sos_reg    <= sum_sq[NUM_W-1:0];
            scaled_reg <= NUM_W'(sq_reg) * NUM_W'(WINDOW);
            // undo the bias: subtracting 32768 flips the top bit
            mean_reg   <= {~mean_prod[K_SH+SW-1], mean_prod[K_SH+SW-2:K_SH]};
        end
    end

    // Bit-serial square root, two radicand bits per step
    assign rem_shift = {rem_reg, x_reg[X_W-1 -: 2]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign rem_diff  = rem_shift - trial;
    assign take      = (rem_shift >= trial);

    always_ff @(posedge aclk) begin
        if (cmd.sub) begin
            x_reg    <= X_W'(scaled_reg - sos_reg);
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cmd.step) begin
            x_reg    <= {x_reg[X_W-3:0], 2'b00};
            rem_reg  <= take ? rem_diff[RT_W+1:0] : rem_shift[RT_W+1:0];
            root_reg <= {root_reg[RT_W-2:0], take};
        end
    end

    // floor(root / WINDOW) equals the deviation of the window
    assign sd_prod = PR_W'(root_reg) * PR_W'(RECIP);

    always_ff @(posedge aclk) begin
        if (cmd.div) begin
            sd_reg <= sd_prod[K_SH +: SW];
        end
    end

    // Result register; statistics read zero until the window is full
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            res_latest_reg <= latest_reg;
            res_full_reg   <= full;
            res_mean_reg   <= full ? mean_reg : '0;
            res_sd_reg     <= full ? sd_reg : '0;
        end
    end

    assign out_latest = res_latest_reg;
    assign out_full   = res_full_reg;
    assign out_mean   = signed'(res_mean_reg);
    assign out_sd     = res_sd_reg;

endmodule

>>> rtl/wmsd_controller.sv
// Controller state machine: request handshake, step sequencing of the
// datapath and the result valid flag. Depends on wmsd_pkg.
`timescale 1ns / 1ps

module wmsd_controller #(
    parameter int WINDOW = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              op_in,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  wmsd_pkg::status_t status,
    output wmsd_pkg::cmd_t    cmd
);

    localparam int RT_W   = 16 + $clog2(WINDOW);
    localparam int STEP_W = $clog2(RT_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(RT_W - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_UPD  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_SUB  = 3'd3;
    localparam logic [2:0] ST_SQRT = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              valid_reg, valid_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    cmd.clear   = (op_in == wmsd_pkg::OP_CLEAR);
                    state_next  = (op_in == wmsd_pkg::OP_CLEAR) ? ST_OUT : ST_UPD;
                end
            end
            ST_UPD: begin
                cmd.update = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = status.full ? ST_SUB : ST_OUT;
            end
            ST_SUB: begin
                cmd.sub    = 1'b1;
                step_next  = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.step  = 1'b1;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // hold until the result register is free
                if (!valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid: set on load, drop when taken
    always_comb begin
        if (cmd.load_out) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;

endmodule

>>> test/tb_top.sv
// Self-checking testbench for windowed_mean_stddev_unit: random and directed requests
// with a built-in window predictor, checked result by result. Depends on wmsd_pkg.
`timescale 1ns / 1ps

module tb_top;

    localparam int WIN         = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_REQS = 650;

    typedef struct {
        logic                          op;
        logic [wmsd_pkg::SAMPLE_W-1:0] smp;
    } req_t;

    typedef struct {
        logic signed [15:0] latest;
        logic               full;
        logic signed [15:0] mean;
        logic        [15:0] sd;
    } stats_t;

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [wmsd_pkg::S_TDATA_W-1:0]   s_tdata  = '0;
    logic [0:0]                       s_tuser  = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [wmsd_pkg::M_TDATA_W-1:0]   m_tdata;
    logic [0:0]                       m_tuser;

    req_t   pending_reqs[$];
    stats_t stats_due_q[$];
    int     reqs_offered  = 0;
    int     reqs_accepted = 0;
    int     mismatches    = 0;
    int     cycle_cnt     = 0;
    logic   steady;

    // Predicted window state
    logic signed [15:0] hist [WIN];
    int unsigned        wr_idx;
    int unsigned        fill;
    longint             acc_sum;
    longint             acc_sq;

    windowed_mean_stddev_unit #(.WINDOW(WIN)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Neither side idles over this stretch of requests
    assign steady = (reqs_offered >= 250) && (reqs_offered < 400);

    // Largest r with r*r <= x, by bisection
    function automatic longint int_root(input longint x);
        longint lo;
        longint hi;
        longint mid;
        lo = 0;
        hi = 65536;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= x) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic void clear_window();
        foreach (hist[i]) hist[i] = '0;
        wr_idx  = 0;
        fill    = 0;
        acc_sum = 0;
        acc_sq  = 0;
    endfunction

    // Apply one request to the predicted window and return the statistics it yields
    function automatic stats_t advance_window(input logic op, input logic signed [15:0] smp);
        stats_t             r;
        logic signed [15:0] leaving;
        longint             spread;
        if (op == wmsd_pkg::OP_CLEAR) begin
            clear_window();
        end else begin
            leaving  = hist[wr_idx];
            acc_sum += longint'(smp) - longint'(leaving);
            acc_sq  += longint'(smp) * longint'(smp) - longint'(leaving) * longint'(leaving);
            hist[wr_idx] = smp;
            wr_idx = (wr_idx + 1) % WIN;
            if (fill < WIN) fill++;
        end
        r.latest = hist[(wr_idx + WIN - 1) % WIN];
        r.full   = (fill >= WIN);
        r.mean   = '0;
        r.sd     = '0;
        if (r.full) begin
            // window length is a power of two: arithmetic shift floors toward minus infinity
            r.mean = 16'(acc_sum >>> $clog2(WIN));
            spread = longint'(WIN) * acc_sq - acc_sum * acc_sum;
            if (spread < 0) spread = 0;
            r.sd = 16'(int_root(spread / (WIN * WIN)));
        end
        return r;
    endfunction

    function automatic void queue_req(input logic op,
                                      input logic [wmsd_pkg::SAMPLE_W-1:0] smp);
        req_t q;
        q.op  = op;
        q.smp = smp;
        pending_reqs.push_back(q);
    endfunction

    // Drive requests and the result-side ready at the falling edge
    always @(negedge aclk) begin
        req_t next_req;
        logic drain_wait;
        if (aresetn) begin
            if (!s_tvalid || reqs_accepted == reqs_offered) begin
                // hold off at a few points until every result is back
                drain_wait = (reqs_offered == 150 || reqs_offered == 500)
                             && stats_due_q.size() != 0;
                if (pending_reqs.size() != 0 && !drain_wait
                        && (steady || $urandom_range(99) >= 35)) begin
                    next_req = pending_reqs.pop_front();
                    s_tuser  <= next_req.op;
                    s_tdata  <= next_req.smp;
                    s_tvalid <= 1'b1;
                    reqs_offered++;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= steady || ($urandom_range(99) >= 35);
        end
    end

    // Predict on each accepted request, check each accepted result
    always @(posedge aclk) begin
        stats_t exp_r;
        stats_t got_r;
        cycle_cnt++;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                stats_due_q.push_back(advance_window(s_tuser[0], s_tdata));
                reqs_accepted++;
            end
            if (m_tvalid && m_tready) begin
                got_r.latest = m_tdata[15:0];
                got_r.mean   = m_tdata[31:16];
                got_r.sd     = m_tdata[47:32];
                got_r.full   = m_tuser[0];
                if (stats_due_q.size() == 0) begin
                    $error("result with no request pending: %h", m_tdata);
                    mismatches++;
                end else begin
                    exp_r = stats_due_q.pop_front();
                    if (got_r.latest !== exp_r.latest) begin
                        $error("latest: expected %0d, got %0d", exp_r.latest, got_r.latest);
                        mismatches++;
                    end
                    if (got_r.full !== exp_r.full) begin
                        $error("window_full: expected %0d, got %0d", exp_r.full, got_r.full);
                        mismatches++;
                    end
                    if (got_r.mean !== exp_r.mean) begin
                        $error("mean_value: expected %0d, got %0d", exp_r.mean, got_r.mean);
                        mismatches++;
                    end
                    if (got_r.sd !== exp_r.sd) begin
                        $error("std_dev: expected %0d, got %0d", exp_r.sd, got_r.sd);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int                            random_left;
        int                            style;
        int                            seg_len;
        logic [wmsd_pkg::SAMPLE_W-1:0] center;
        logic [wmsd_pkg::SAMPLE_W-1:0] smp;
        clear_window();

        // clear from reset with a sample that must be ignored
        queue_req(wmsd_pkg::OP_CLEAR, 16'hFFFF);
        queue_req(wmsd_pkg::OP_ADD, 16'h7FFF);
        queue_req(wmsd_pkg::OP_ADD, 16'h8000);
        // clear in the middle of filling
        queue_req(wmsd_pkg::OP_CLEAR, 16'h8000);
        // fill with alternating extremes: widest spread, negative mean that floors
        for (int i = 0; i < WIN; i++) begin
            queue_req(wmsd_pkg::OP_ADD, (i % 2) ? 16'h8000 : 16'h7FFF);
        end
        // wrap the pointer and overwrite the oldest entries
        queue_req(wmsd_pkg::OP_ADD, 16'h7FFF);
        queue_req(wmsd_pkg::OP_ADD, 16'h8000);
        queue_req(wmsd_pkg::OP_CLEAR, 16'h1234);

        // random segments of a few styles, with sparse clears
        random_left = RANDOM_REQS;
        while (random_left > 0) begin
            style   = $urandom_range(3);
            seg_len = $urandom_range(20, 60);
            center  = 16'($urandom);
            for (int k = 0; k < seg_len && random_left > 0; k++) begin
                if ($urandom_range(99) < 2) begin
                    queue_req(wmsd_pkg::OP_CLEAR, 16'($urandom));
                end else begin
                    case (style)
                        0: smp = 16'($urandom);
                        1: smp = $urandom_range(1) ? 16'h7FFF : 16'h8000;
                        2: begin
                            // constant run, sometimes stepping to a new level
                            if ($urandom_range(9) == 0) center = 16'($urandom);
                            smp = center;
                        end
                        default: smp = center + 16'($urandom_range(200)) - 16'd100;
                    endcase
                    queue_req(wmsd_pkg::OP_ADD, smp);
                end
                random_left--;
            end
        end

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        wait (pending_reqs.size() == 0 && reqs_accepted == reqs_offered);
        wait (stats_due_q.size() == 0);
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && stats_due_q.size() == 0) begin
            $display("windowed_mean_stddev_unit: match");
        end else begin
            $display("windowed_mean_stddev_unit: mismatch");
        end
        $finish;
    end

    // Watchdog
    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("windowed_mean_stddev_unit: mismatch");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/wmsd_pkg.sv
rtl/wmsd_datapath.sv
rtl/wmsd_controller.sv
rtl/windowed_mean_stddev_unit.sv
test/tb_top.sv
